// File: rtl/gbs_pkg.sv
// Shared widths, types and register codes for the greedy box suppression block.
`default_nettype none

package gbs_pkg;

  localparam int MAX_KEPT_DEFAULT = 64;

  localparam int COORD_W = 16;
  localparam int LEN_W   = 15;
  localparam int CLASS_W = 7;
  localparam int AREA_W  = 2 * LEN_W;
  localparam int INDEX_W = 16;
  localparam int THR_W   = 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd115;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_OVERLAP_THRESHOLD = 1'b0,
    CFG_CLASS_AGNOSTIC    = 1'b1
  } cfg_reg_t;

  // Candidate box under test
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [LEN_W-1:0]          w;
    logic [LEN_W-1:0]          h;
    logic [CLASS_W-1:0]        cls;
  } box_t;

  // One entry of the kept store
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [LEN_W-1:0]          width;
    logic [LEN_W-1:0]          height;
    logic [CLASS_W-1:0]        cls;
    logic [AREA_W-1:0]         area;
  } entry_t;

  // Status of the overlap test pipeline
  typedef struct packed {
    logic busy;
    logic hit;
  } iou_status_t;

endpackage

`default_nettype wire

// File: rtl/gbs_if.sv
// Valid/ready channel interfaces for candidate boxes and suppression results.
`default_nettype none

interface gbs_box_if;
  import gbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      start_of_set;
  logic signed [COORD_W-1:0] box_x;
  logic signed [COORD_W-1:0] box_y;
  logic [LEN_W-1:0]          box_w;
  logic [LEN_W-1:0]          box_h;
  logic [CLASS_W-1:0]        class_label;

  modport source (
    output valid, start_of_set, box_x, box_y, box_w, box_h, class_label,
    input  ready
  );

  modport sink (
    input  valid, start_of_set, box_x, box_y, box_w, box_h, class_label,
    output ready
  );
endinterface

interface gbs_result_if;
  import gbs_pkg::*;

  logic               valid;
  logic               ready;
  logic               keep;
  logic [INDEX_W-1:0] box_index;
  logic               store_full;

  modport source (
    output valid, keep, box_index, store_full,
    input  ready
  );

  modport sink (
    input  valid, keep, box_index, store_full,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/gbs_store.sv
// Kept-box store: one write port, one read port with registered read data.
`default_nettype none

module gbs_store #(
  parameter int DEPTH = gbs_pkg::MAX_KEPT_DEFAULT,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  gbs_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output gbs_pkg::entry_t rd_data
);
  import gbs_pkg::*;

  entry_t mem [DEPTH];

  // Write a kept box
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one stored box per cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gbs_iou_unit.sv
// Pipelined overlap test of the candidate box against one stored box per cycle.
`default_nettype none

module gbs_iou_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          entry_valid,
  input  gbs_pkg::entry_t               entry,
  input  gbs_pkg::box_t                 box,
  input  logic [gbs_pkg::AREA_W-1:0]    box_area,
  input  logic [gbs_pkg::THR_W-1:0]     overlap_threshold,
  input  logic                          class_agnostic,
  output gbs_pkg::iou_status_t          status
);
  import gbs_pkg::*;

  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_W + UNI_W;

  // Length of the overlap of two intervals, zero when they do not overlap
  function automatic logic [LEN_W-1:0] overlap_len(
    input logic signed [COORD_W-1:0] a0,
    input logic [LEN_W-1:0]          al,
    input logic signed [COORD_W-1:0] b0,
    input logic [LEN_W-1:0]          bl
  );
    logic signed [COORD_W+1:0] a1;
    logic signed [COORD_W+1:0] b1;
    logic signed [COORD_W+1:0] lo;
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] d;
    a1 = (COORD_W+2)'(a0) + $signed({3'b000, al});
    b1 = (COORD_W+2)'(b0) + $signed({3'b000, bl});
    lo = (a0 > b0) ? (COORD_W+2)'(a0) : (COORD_W+2)'(b0);
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    return (hi > lo) ? d[LEN_W-1:0] : '0;
  endfunction

  logic               v2, v3, v4, v5, hit;
  logic [LEN_W-1:0]   ow2, oh2;
  logic [AREA_W-1:0]  ka2, ka3;
  logic [AREA_W-1:0]  inter3, inter4, inter5;
  logic [UNI_W-1:0]   uni4;
  logic [PROD_W-1:0]  prod5;

  // Stage valids; if class-aware, an entry of another class drops at the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      hit <= 1'b0;
    end else begin
      v2  <= entry_valid && (class_agnostic || entry.cls == box.cls);
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      hit <= v5 && ({1'b0, inter5, 8'd0} > prod5);
    end
  end

  // Datapath: overlap lengths, intersection, union, scaled union
  always_ff @(posedge clk) begin
    ow2    <= overlap_len(box.x, box.w, entry.left, entry.width);
    oh2    <= overlap_len(box.y, box.h, entry.top, entry.height);
    ka2    <= entry.area;
    inter3 <= AREA_W'(ow2) * AREA_W'(oh2);
    ka3    <= ka2;
    uni4   <= UNI_W'(box_area) + UNI_W'(ka3) - UNI_W'(inter3);
    inter4 <= inter3;
    prod5  <= PROD_W'(overlap_threshold) * PROD_W'(uni4);
    inter5 <= inter4;
  end

  assign status.busy = v2 | v3 | v4 | v5 | hit;
  assign status.hit  = hit;

endmodule

`default_nettype wire

// File: rtl/greedy_box_suppression_core.sv
// Greedy non-maximum suppression of score-ordered boxes by intersection over union.
//
// Boxes enter on the boxes channel (valid/ready, one box per beat) in falling
// score order; one result beat per box leaves on the results channel with the
// keep flag, the box position within its set and the store-full flag.
// A box with start_of_set high empties the kept store and restarts the index.
// Each box is tested against the K boxes kept so far in its set, one stored
// box per cycle through the store's single read port and an overlap test
// pipeline. The accepted box has its area formed, the kept boxes are read out,
// the pipeline drains and the result is registered; a new box is taken only in
// the cycle after the result is registered, never while one is under test.
// The result sits in an output register: the next box is accepted and
// tested while it waits, and that box stalls in its final step until the
// receiver takes the pending beat.
// Reset empties the store, clears the index and sets the threshold to 115/256
// with class-aware comparison. Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write only while no box is in flight (unenforced).
`default_nettype none

module greedy_box_suppression_core #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  gbs_box_if.sink                         boxes,
  gbs_result_if.source                    results,
  input  logic                            cfg_we,
  input  logic [gbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gbs_pkg::*;

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam logic [CW-1:0] KEPT_MAX = CW'(MAX_KEPT);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_AREA   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t             state;
  logic [THR_W-1:0]   overlap_threshold;
  logic               class_agnostic;
  box_t               box;
  logic [AREA_W-1:0]  box_area;
  logic [INDEX_W-1:0] box_index;
  logic [INDEX_W-1:0] item_count;
  logic [CW-1:0]      kept_count;
  logic [CW-1:0]      scan_cnt;
  logic               rd_valid;
  logic               suppress;
  logic               res_valid;
  logic               res_keep;
  logic               res_full;
  logic [INDEX_W-1:0] res_index;

  logic               rd_en;
  logic               finish_go;
  logic               store_room;
  logic               wr_en;
  logic               pipe_busy;
  entry_t             wr_data;
  entry_t             rd_data;
  iou_status_t        iou_status;

  // Handshake and sequencing terms
  assign boxes.ready = (state == ST_IDLE);
  assign rd_en       = (state == ST_SCAN) && (scan_cnt != kept_count);
  assign finish_go   = (state == ST_FINISH) && (!res_valid || results.ready);
  assign store_room  = (kept_count != KEPT_MAX);
  assign wr_en       = finish_go && !suppress && store_room;
  assign pipe_busy   = rd_valid | iou_status.busy;

  assign wr_data.left   = box.x;
  assign wr_data.top    = box.y;
  assign wr_data.width  = box.w;
  assign wr_data.height = box.h;
  assign wr_data.cls    = box.cls;
  assign wr_data.area   = box_area;

  gbs_store #(
    .DEPTH (MAX_KEPT),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (kept_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_cnt[AW-1:0]),
    .rd_data (rd_data)
  );

  gbs_iou_unit u_iou (
    .clk               (clk),
    .rst               (rst),
    .entry_valid       (rd_valid),
    .entry             (rd_data),
    .box               (box),
    .box_area          (box_area),
    .overlap_threshold (overlap_threshold),
    .class_agnostic    (class_agnostic),
    .status            (iou_status)
  );

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      overlap_threshold <= THRESHOLD_RESET;
      class_agnostic    <= 1'b0;
      item_count        <= '0;
      kept_count        <= '0;
      scan_cnt          <= '0;
      rd_valid          <= 1'b0;
      suppress          <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OVERLAP_THRESHOLD: overlap_threshold <= cfg_data[THR_W-1:0];
          CFG_CLASS_AGNOSTIC:    class_agnostic    <= cfg_data[0];
          default: ;
        endcase
      end

      rd_valid <= rd_en;
      // Clear the verdict while idle, collect hits while a box is tested
      suppress <= (state == ST_IDLE) ? 1'b0 : (suppress | iou_status.hit);

      // Load a new result, or hold the pending one until the receiver takes it
      res_valid <= finish_go || (res_valid && !results.ready);

      case (state)
        ST_IDLE: begin
          if (boxes.valid) begin
            box.x    <= boxes.box_x;
            box.y    <= boxes.box_y;
            box.w    <= boxes.box_w;
            box.h    <= boxes.box_h;
            box.cls  <= boxes.class_label;
            scan_cnt <= '0;
            if (boxes.start_of_set) begin
              kept_count <= '0;
              box_index  <= '0;
              item_count <= INDEX_W'(1);
            end else begin
              box_index  <= item_count;
              item_count <= item_count + INDEX_W'(1);
            end
            state <= ST_AREA;
          end
        end
        ST_AREA: begin
          box_area <= AREA_W'(box.w) * AREA_W'(box.h);
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_cnt <= scan_cnt + CW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            res_keep  <= !suppress;
            res_full  <= !suppress && !store_room;
            res_index <= box_index;
            if (wr_en) begin
              kept_count <= kept_count + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign results.valid      = res_valid;
  assign results.keep       = res_keep;
  assign results.store_full = res_full;
  assign results.box_index  = res_index;

  // The store never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) kept_count <= KEPT_MAX)
    else $error("kept count beyond store depth");

  // The scan never reads past the kept boxes
  assert property (@(posedge clk) disable iff (rst) scan_cnt <= kept_count)
    else $error("scan index beyond kept count");

  // The verdict is only taken with the test pipeline empty
  assert property (@(posedge clk) disable iff (rst) (state == ST_FINISH) |-> !pipe_busy)
    else $error("result formed while overlap tests in flight");

  // A full-store flag only comes with a kept box
  assert property (@(posedge clk) disable iff (rst)
                   results.valid |-> (results.keep || !results.store_full))
    else $error("store full flagged on a dropped box");

endmodule

`default_nettype wire

// File: test/greedy_box_suppression_core_tb.sv
// Self-checking testbench for the greedy box suppression core.

module greedy_box_suppression_core_tb;
  import gbs_pkg::*;

  localparam int MAX_KEPT     = MAX_KEPT_DEFAULT;
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASES       = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = MAX_KEPT + 20;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic start;
    box_t box;
  } box_beat_t;

  typedef struct packed {
    logic               keep;
    logic [INDEX_W-1:0] index;
    logic               full;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gbs_box_if    boxes();
  gbs_result_if results();

  greedy_box_suppression_core #(.MAX_KEPT(MAX_KEPT)) dut (
    .clk       (clk),
    .rst       (rst),
    .boxes     (boxes),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Kept-box store and registers as the suppression logic should see them
  logic signed [COORD_W-1:0] store_left   [MAX_KEPT];
  logic signed [COORD_W-1:0] store_top    [MAX_KEPT];
  logic [LEN_W-1:0]          store_width  [MAX_KEPT];
  logic [LEN_W-1:0]          store_height [MAX_KEPT];
  logic [CLASS_W-1:0]        store_class  [MAX_KEPT];
  logic [AREA_W-1:0]         store_area   [MAX_KEPT];
  int unsigned               kept_total;
  logic [INDEX_W-1:0]        set_position;
  logic [THR_W-1:0]          threshold;
  logic                      agnostic;

  box_beat_t   box_queue[$];
  verdict_t    verdict_queue[$];
  box_beat_t   driven_box;
  int          queued;
  int          gap_left;
  int          stall_left;
  int          cycles;
  bit          calm;
  int unsigned errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Length of the overlap of [a0, a0+al) and [b0, b0+bl), zero if none
  function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // Decide one box against the kept store and update the store
  function automatic verdict_t suppress_box(box_beat_t beat);
    verdict_t v;
    longint   bx, by, bw, bh;
    longint   area, inter, uni;
    int       j;
    bx = $signed(beat.box.x);
    by = $signed(beat.box.y);
    bw = beat.box.w;
    bh = beat.box.h;
    area = bw * bh;
    v.keep = 1'b1;
    v.full = 1'b0;
    if (beat.start) begin
      kept_total = 0;
      set_position = '0;
    end
    v.index = set_position;
    set_position = set_position + 1'b1;
    for (j = 0; j < kept_total; j++) begin
      if (v.keep && (agnostic || store_class[j] == beat.box.cls)) begin
        inter = span_overlap(bx, bw, store_left[j], store_width[j]) *
                span_overlap(by, bh, store_top[j], store_height[j]);
        uni = area + longint'(store_area[j]) - inter;
        if (inter * 256 > longint'(threshold) * uni) v.keep = 1'b0;
      end
    end
    if (v.keep) begin
      if (kept_total < MAX_KEPT) begin
        store_left[kept_total]   = beat.box.x;
        store_top[kept_total]    = beat.box.y;
        store_width[kept_total]  = beat.box.w;
        store_height[kept_total] = beat.box.h;
        store_class[kept_total]  = beat.box.cls;
        store_area[kept_total]   = area;
        kept_total++;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  task automatic add_box(logic st, logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                         logic [LEN_W-1:0] w, logic [LEN_W-1:0] h, logic [CLASS_W-1:0] cls);
    box_beat_t beat;
    beat.start   = st;
    beat.box.x   = x;
    beat.box.y   = y;
    beat.box.w   = w;
    beat.box.h   = h;
    beat.box.cls = cls;
    box_queue.insert(box_queue.size(), beat);
    queued++;
  endtask

  // Queue one set of boxes, or a stray beat with arbitrary fields
  task automatic add_random_set();
    int pick, len, k, slot, slots, jx, jy, cx, cy;
    logic [LEN_W-1:0]   w, h;
    logic [CLASS_W-1:0] cls;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_box($urandom_range(0, 4) == 0, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    len   = (pick < 30) ? $urandom_range(MAX_KEPT + 1, MAX_KEPT + 26) : $urandom_range(1, 24);
    slots = $urandom_range(2, 8);
    for (k = 0; k < len; k++) begin
      // walk the grid in big sets so most boxes survive and the store overflows
      if (pick < 30)
        slot = ($urandom_range(0, 4) != 0) ? k : $urandom_range(0, k);
      else
        slot = $urandom_range(0, slots - 1);
      cx = (slot % 10) * 640 - 3200;
      cy = (slot / 10) * 640 - 3200;
      jx = $urandom_range(0, 320);
      jy = $urandom_range(0, 320);
      w = ($urandom_range(0, 19) == 0) ? '0 : LEN_W'($urandom_range(192, 320));
      h = ($urandom_range(0, 19) == 0) ? '0 : LEN_W'($urandom_range(192, 320));
      cls = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom_range(0, 127))
                                         : CLASS_W'($urandom_range(0, 2));
      add_box(k == 0, cx + jx - 160, cy + jy - 160, w, h, cls);
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OVERLAP_THRESHOLD: threshold = value;
      CFG_CLASS_AGNOSTIC:    agnostic = value[0];
      default: ;
    endcase
  endtask

  // Hold until every queued box is sent and every verdict has come back;
  // sample between edges so a freshly loaded beat is seen
  task automatic wait_idle();
    @(negedge clk);
    while (box_queue.size() != 0 || boxes.valid || verdict_queue.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [INDEX_W-1:0] want, logic [INDEX_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Box driver: predict each accepted beat, then pause or load the next one
  always @(posedge clk) begin : drive_boxes
    logic drive;
    if (rst) begin
      boxes.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (boxes.valid && boxes.ready)
        verdict_queue.insert(verdict_queue.size(), suppress_box(driven_box));
      if (!boxes.valid || boxes.ready) begin
        drive = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 7);
        end else if (box_queue.size() > 0) begin
          driven_box = box_queue.pop_front();
          drive = 1'b1;
        end
        boxes.valid        <= drive;
        boxes.start_of_set <= driven_box.start;
        boxes.box_x        <= driven_box.box.x;
        boxes.box_y        <= driven_box.box.y;
        boxes.box_w        <= driven_box.box.w;
        boxes.box_h        <= driven_box.box.h;
        boxes.class_label  <= driven_box.box.cls;
      end
    end
  end

  // Result monitor: check each beat against the oldest verdict, stall in bursts
  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (rst) begin
      results.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (verdict_queue.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual index %0d",
                     $time, results.box_index);
        end else begin
          want = verdict_queue.pop_front();
          if (results.keep !== want.keep)
            report_field("keep", want.keep, results.keep);
          if (results.box_index !== want.index)
            report_field("box_index", want.index, results.box_index);
          if (results.store_full !== want.full)
            report_field("store_full", want.full, results.store_full);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        results.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int               target;
    logic [THR_W-1:0] thr;
    logic [6:0]       junk;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_OVERLAP_THRESHOLD;
    cfg_data            = '0;
    boxes.valid         = 1'b0;
    boxes.start_of_set  = 1'b0;
    boxes.box_x         = '0;
    boxes.box_y         = '0;
    boxes.box_w         = '0;
    boxes.box_h         = '0;
    boxes.class_label   = '0;
    results.ready       = 1'b0;
    driven_box          = '0;
    kept_total          = 0;
    set_position        = '0;
    threshold           = THRESHOLD_RESET;
    agnostic            = 1'b0;
    queued              = 0;
    cycles              = 0;
    calm                = 1'b0;
    errors              = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed boxes under the reset settings
    add_box(1,   0,   0, 160, 160, 1);   // first box of a set, kept
    add_box(0,   0,   0, 160, 160, 1);   // identical box, dropped
    add_box(0,   0,   0, 160, 160, 2);   // other class, not compared
    add_box(0,  80,   0, 160, 160, 1);   // IoU one third, below threshold
    add_box(0, 240,   0, 160, 160, 1);   // touches the box above, no overlap
    add_box(0,  10,  10,   0,   0, 1);   // empty box
    add_box(0,  10,  10,   0,   0, 1);   // zero-area union, kept
    add_box(0, 500, 500,  40,   0, 3);   // flat box
    add_box(0, 500, 500,  40,   0, 3);
    add_box(1, -32768, -32768, 32767, 32767, 127);
    add_box(0,  32767,  32767, 32767, 32767, 127);
    add_box(0, -32768, -32768, 32767, 32767, 127);
    add_box(0,    -16,    -16, 32767,     1, 127);
    add_box(0,  32767, -32768,     0, 32767,   0);
    add_box(0, -32768,  32767, 32767,     0,   0);
    add_box(0,  16'sh5555, -16'sh2aab, 15'h2aaa, 15'h5555, 7'h55);
    add_box(0, -16'sh5556,  16'sh2aaa, 15'h5555, 15'h2aaa, 7'h2a);
    add_box(1,    100,    100,    64,    64,  9);
    add_box(0,    108,    100,    64,    64,  9);   // heavy overlap, dropped
    add_box(0,    132,    100,    64,    64,  9);   // half overlap, kept

    // Random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THRESHOLD_RESET;
        default: thr = $urandom_range(1, 254);
      endcase
      junk = $urandom;
      write_reg(CFG_OVERLAP_THRESHOLD, thr);
      write_reg(CFG_CLASS_AGNOSTIC, {junk, p[0]});
      calm = (p == PHASES - 1);
      target = queued + PHASE_ITEMS;
      while (queued < target) add_random_set();
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_queue.size() != 0) errors++;
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
rtl/gbs_pkg.sv
rtl/gbs_if.sv
rtl/gbs_store.sv
rtl/gbs_iou_unit.sv
rtl/greedy_box_suppression_core.sv
test/greedy_box_suppression_core_tb.sv
